// File: rtl/type4_tag_ndef_read_sequencer_core_defines.svh
// Assertion macros for the Type 4 tag NDEF read sequencer RTL.
`ifndef TYPE4_TAG_NDEF_READ_SEQUENCER_CORE_DEFINES_SVH
`define TYPE4_TAG_NDEF_READ_SEQUENCER_CORE_DEFINES_SVH

// Check an implication on every clock edge outside reset.
`define T4NDEF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle outside reset.
`define T4NDEF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/t4ndef_pkg.sv
// Shared types, constants and command tables for the Type 4 tag NDEF read sequencer.
`default_nettype none
package t4ndef_pkg;

    localparam int TRANSPORT_MAX_RESPONSE = 256;
    localparam logic [8:0]  RESP_LIMIT = 9'(TRANSPORT_MAX_RESPONSE);
    localparam logic [15:0] CHUNK_CAP  = 16'(TRANSPORT_MAX_RESPONSE - 2);

    localparam logic [1:0] ACT_DETECT = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_BYTE   = 2'd2;
    localparam logic [1:0] ACT_FAIL   = 2'd3;

    localparam logic [1:0] KIND_CMD    = 2'd0;
    localparam logic [1:0] KIND_FILE   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_IO       = 3'd1;
    localparam logic [2:0] ST_NOTSUPP  = 3'd2;
    localparam logic [2:0] ST_NOSPACE  = 3'd3;
    localparam logic [2:0] ST_TRANSPORT = 3'd4;

    localparam logic [7:0] SW1_OK   = 8'h90;
    localparam logic [7:0] SW1_ERR  = 8'h6A;
    localparam logic [7:0] SW2_NF   = 8'h82;
    localparam logic [7:0] CC_TYPE  = 8'h04;

    localparam logic [7:0] APP_V2 [13] = '{8'h00, 8'hA4, 8'h04, 8'h00, 8'h07, 8'hD2, 8'h76,
                                          8'h00, 8'h00, 8'h85, 8'h01, 8'h01, 8'h00};
    localparam logic [7:0] APP_V1 [12] = '{8'h00, 8'hA4, 8'h04, 8'h00, 8'h07, 8'hD2, 8'h76,
                                          8'h00, 8'h00, 8'h85, 8'h01, 8'h00};
    localparam logic [7:0] SEL_CC [7]  = '{8'h00, 8'hA4, 8'h00, 8'h0C, 8'h02, 8'hE1, 8'h03};

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_APP2,
        CMD_APP1,
        CMD_SELCC,
        CMD_READCC,
        CMD_SELFILE,
        CMD_READ
    } t_cmd;

    // One accepted item's worth of results: optional file byte, then a command or a status.
    typedef struct packed {
        logic        has_file;
        logic [7:0]  file_byte;
        t_cmd        cmd;
        logic [15:0] arg;
        logic [7:0]  le;
        logic        has_status;
        logic [2:0]  status;
    } t_burst;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       last_of_run;
        logic [2:0] status_code;
    } t_item;

    function automatic logic [3:0] cmd_len(input t_cmd cmd);
        logic [3:0] len;
        unique case (cmd)
            CMD_APP2:    len = 4'd13;
            CMD_APP1:    len = 4'd12;
            CMD_SELCC:   len = 4'd7;
            CMD_READCC:  len = 4'd5;
            CMD_SELFILE: len = 4'd7;
            CMD_READ:    len = 4'd5;
            default:     len = 4'd0;
        endcase
        return len;
    endfunction

    // ReadBinary header is common; SELFILE and READ carry a 16-bit argument.
    function automatic logic [7:0] cmd_byte(input t_cmd cmd, input logic [3:0] k,
                                            input logic [15:0] arg, input logic [7:0] le);
        logic [7:0] b;
        b = 8'h00;
        unique case (cmd)
            CMD_APP2:  b = APP_V2[k];
            CMD_APP1:  b = (k < 4'd12) ? APP_V1[k] : 8'h00;
            CMD_SELCC: b = SEL_CC[k[2:0]];
            CMD_READCC: begin
                unique case (k)
                    4'd1:    b = 8'hB0;
                    4'd4:    b = 8'h0F;
                    default: b = 8'h00;
                endcase
            end
            CMD_SELFILE: begin
                unique case (k)
                    4'd5:    b = arg[15:8];
                    4'd6:    b = arg[7:0];
                    default: b = (k < 4'd5) ? SEL_CC[k[2:0]] : 8'h00;
                endcase
            end
            CMD_READ: begin
                unique case (k)
                    4'd1:    b = 8'hB0;
                    4'd2:    b = arg[15:8];
                    4'd3:    b = arg[7:0];
                    4'd4:    b = le;
                    default: b = 8'h00;
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// File: rtl/t4ndef_if.sv
// Valid/ready channel interfaces for request items and result items.
`default_nettype none
interface t4ndef_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic       rx_last;
    modport source (output valid, action, rx_byte, rx_last, input ready);
    modport sink   (input valid, action, rx_byte, rx_last, output ready);
endinterface

interface t4ndef_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic [2:0] status_code;
    modport source (output valid, kind, out_byte, last_of_run, status_code, input ready);
    modport sink   (input valid, kind, out_byte, last_of_run, status_code, output ready);
endinterface
`default_nettype wire

// File: rtl/type4_tag_ndef_read_sequencer_core.sv
// Top level of the Type 4 tag NDEF read sequencer: register port, sequencer, serializer.
//
//  channel   dir  handshake      carries
//  i_in      in   valid/ready    action, rx_byte, rx_last
//  o_out     out  valid/ready    kind, out_byte, last_of_run, status_code
//  apb       in   psel/penable   max_ndef_length at byte address 0
//
// Each request transfer is decoded in the cycle it is taken; its results (up to
// thirteen: an optional file byte, then a command or a status) go to a one-burst
// slot and leave one per cycle, while the output is ready, through a registered
// output stage. A new request is taken whenever the slot is free, so requests
// overlap the previous burst. Reset is synchronous, active low, and clears the
// phase and the burst buffers; a stalled output holds.
`default_nettype none
module type4_tag_ndef_read_sequencer_core
    import t4ndef_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    t4ndef_in_if.sink        i_in,
    t4ndef_out_if.source     o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Maximum accepted NDEF length; the user must write it only while no sequence runs (not enforced here).
    logic [15:0] r_max_len;
    logic        slot_free;
    logic        load;
    t_burst      burst;

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {16'd0, r_max_len} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= 16'd1024;
        end else if (psel && penable && pwrite && paddr == 3'd0) begin
            r_max_len <= pwdata[15:0];
        end
    end

    // Decode each request and advance the protocol phase.
    t4ndef_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_len   (r_max_len),
        .i_slot_free (slot_free),
        .i_in        (i_in),
        .o_burst     (burst),
        .o_load      (load)
    );

    // Hold the burst and transfer its items one at a time.
    t4ndef_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_burst     (burst),
        .o_slot_free (slot_free),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

// File: rtl/t4ndef_seq.sv
// Protocol state machine: consumes one item per transfer and, where it has results, produces a result burst.
`default_nettype none
module t4ndef_seq
    import t4ndef_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_max_len,
    input  wire logic        i_slot_free,
    t4ndef_in_if.sink        i_in,
    output t_burst           o_burst,
    output logic             o_load
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_APP2, PH_APP1, PH_SELCC, PH_READCC, PH_SELFILE, PH_NLEN, PH_CHUNK
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_detect, n_detect;
    logic [8:0]  r_count, n_count;
    logic [15:0] r_pair, n_pair;
    logic [15:0] r_mrl, n_mrl;
    logic [15:0] r_fid, n_fid;
    logic        r_type_ok, n_type_ok;
    logic [15:0] r_mlen, n_mlen;
    logic [15:0] r_done, n_done;
    logic [7:0]  r_chunk, n_chunk;

    logic        accept;
    logic [8:0]  cnt;
    logic [15:0] sw;
    logic        ok;
    logic [15:0] done_sum;
    t_burst      burst;

    function automatic logic [7:0] chunk_for(input logic [15:0] mlen, input logic [15:0] done,
                                             input logic [15:0] mrl);
        logic [15:0] c;
        logic [15:0] cap;
        c   = mlen - done;
        cap = mrl - 16'd1;
        if (c > cap) c = cap;
        if (c > CHUNK_CAP) c = CHUNK_CAP;
        return c[7:0];
    endfunction

    assign i_in.ready = i_slot_free;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_phase   = r_phase;
        n_detect  = r_detect;
        n_count   = r_count;
        n_pair    = r_pair;
        n_mrl     = r_mrl;
        n_fid     = r_fid;
        n_type_ok = r_type_ok;
        n_mlen    = r_mlen;
        n_done    = r_done;
        n_chunk   = r_chunk;
        burst     = '0;
        burst.cmd = CMD_NONE;
        cnt       = (r_count < 9'd511) ? r_count + 9'd1 : r_count;
        sw        = {r_pair[7:0], i_in.rx_byte};
        ok        = (cnt >= 9'd2) && (sw == {SW1_OK, 8'h00});
        done_sum  = r_done + {8'h00, r_chunk};

        if (i_in.action == ACT_DETECT || i_in.action == ACT_READ) begin
            n_detect  = (i_in.action == ACT_DETECT);
            n_count   = '0;
            n_pair    = '0;
            burst.cmd = CMD_APP2;
            n_phase   = PH_APP2;
        end else if (r_phase == PH_IDLE) begin
            // drop stray bytes and failures while idle
        end else if (i_in.action == ACT_FAIL) begin
            n_count          = '0;
            n_pair           = '0;
            burst.has_status = 1'b1;
            burst.status     = ST_TRANSPORT;
            n_phase          = PH_IDLE;
        end else begin
            // pass file bytes on two bytes late so the status word never leaves
            if ((r_phase == PH_NLEN || r_phase == PH_CHUNK) && r_count >= 9'd2 &&
                (r_count - 9'd2) < ((r_phase == PH_NLEN) ? 9'd2 : {1'b0, r_chunk})) begin
                burst.has_file  = 1'b1;
                burst.file_byte = r_pair[15:8];
            end
            if (r_phase == PH_READCC) begin
                unique case (r_count)
                    9'd3:    n_mrl     = {i_in.rx_byte, r_mrl[7:0]};
                    9'd4:    n_mrl     = {r_mrl[15:8], i_in.rx_byte};
                    9'd7:    n_type_ok = (i_in.rx_byte == CC_TYPE);
                    9'd9:    n_fid     = {i_in.rx_byte, r_fid[7:0]};
                    9'd10:   n_fid     = {r_fid[15:8], i_in.rx_byte};
                    default: ;
                endcase
            end else if (r_phase == PH_NLEN) begin
                if (r_count == 9'd0)      n_mlen = {i_in.rx_byte, r_mlen[7:0]};
                else if (r_count == 9'd1) n_mlen = {r_mlen[15:8], i_in.rx_byte};
            end
            n_pair  = sw;
            n_count = cnt;

            if (i_in.rx_last) begin
                n_count = '0;
                n_pair  = '0;
                burst.status = ST_IO;
                if (cnt > RESP_LIMIT) begin
                    burst.has_status = 1'b1;
                    burst.status     = ST_TRANSPORT;
                    n_phase          = PH_IDLE;
                end else begin
                    unique case (r_phase)
                        PH_APP2, PH_APP1: begin
                            if (ok) begin
                                if (r_detect) begin
                                    burst.has_status = 1'b1;
                                    burst.status     = ST_OK;
                                    n_phase          = PH_IDLE;
                                end else begin
                                    burst.cmd = CMD_SELCC;
                                    n_phase   = PH_SELCC;
                                end
                            end else if (r_phase == PH_APP2) begin
                                burst.cmd = CMD_APP1;
                                n_phase   = PH_APP1;
                            end else begin
                                burst.has_status = 1'b1;
                                burst.status = (r_detect && cnt >= 9'd2 &&
                                                sw == {SW1_ERR, SW2_NF}) ? ST_NOTSUPP : ST_IO;
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_SELCC: begin
                            if (ok) begin
                                burst.cmd = CMD_READCC;
                                n_phase   = PH_READCC;
                            end else begin
                                burst.has_status = 1'b1;
                                n_phase          = PH_IDLE;
                            end
                        end
                        PH_READCC: begin
                            if (ok && cnt == 9'd17 && n_type_ok) begin
                                if (n_mrl < 16'd2) n_mrl = 16'd2;
                                burst.cmd = CMD_SELFILE;
                                burst.arg = n_fid;
                                n_phase   = PH_SELFILE;
                            end else begin
                                burst.has_status = 1'b1;
                                n_phase          = PH_IDLE;
                            end
                        end
                        PH_SELFILE: begin
                            if (ok) begin
                                burst.cmd = CMD_READ;
                                burst.arg = 16'd0;
                                burst.le  = 8'd2;
                                n_phase   = PH_NLEN;
                            end else begin
                                burst.has_status = 1'b1;
                                n_phase          = PH_IDLE;
                            end
                        end
                        PH_NLEN: begin
                            if (!ok || cnt != 9'd4) begin
                                burst.has_status = 1'b1;
                                n_phase          = PH_IDLE;
                            end else if (n_mlen > i_max_len) begin
                                burst.has_status = 1'b1;
                                burst.status     = ST_NOSPACE;
                                n_phase          = PH_IDLE;
                            end else begin
                                n_done = 16'd0;
                                if (n_mlen == 16'd0) begin
                                    burst.has_status = 1'b1;
                                    burst.status     = ST_OK;
                                    n_phase          = PH_IDLE;
                                end else begin
                                    n_chunk   = chunk_for(n_mlen, 16'd0, r_mrl);
                                    burst.cmd = CMD_READ;
                                    burst.arg = 16'd2;
                                    burst.le  = n_chunk;
                                    n_phase   = PH_CHUNK;
                                end
                            end
                        end
                        PH_CHUNK: begin
                            if (!ok || (cnt - 9'd2) < {1'b0, r_chunk}) begin
                                burst.has_status = 1'b1;
                                n_phase          = PH_IDLE;
                            end else begin
                                n_done = done_sum;
                                if (done_sum >= r_mlen) begin
                                    burst.has_status = 1'b1;
                                    burst.status     = ST_OK;
                                    n_phase          = PH_IDLE;
                                end else begin
                                    n_chunk   = chunk_for(r_mlen, done_sum, r_mrl);
                                    burst.cmd = CMD_READ;
                                    burst.arg = done_sum + 16'd2;
                                    burst.le  = n_chunk;
                                    n_phase   = PH_CHUNK;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                if (!burst.has_status) burst.status = ST_OK;
            end
        end
    end

    assign o_burst = burst;
    assign o_load  = accept && (burst.has_file || burst.has_status || burst.cmd != CMD_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_detect  <= 1'b0;
            r_count   <= '0;
            r_pair    <= '0;
            r_mrl     <= 16'd2;
            r_fid     <= '0;
            r_type_ok <= 1'b0;
            r_mlen    <= '0;
            r_done    <= '0;
            r_chunk   <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_detect  <= n_detect;
            r_count   <= n_count;
            r_pair    <= n_pair;
            r_mrl     <= n_mrl;
            r_fid     <= n_fid;
            r_type_ok <= n_type_ok;
            r_mlen    <= n_mlen;
            r_done    <= n_done;
            r_chunk   <= n_chunk;
        end
    end

endmodule
`default_nettype wire

// File: rtl/t4ndef_emit.sv
// Burst buffer and result serializer: one result item per output transfer.
`default_nettype none
`include "type4_tag_ndef_read_sequencer_core_defines.svh"
module t4ndef_emit
    import t4ndef_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_load,
    input  wire t_burst i_burst,
    output logic        o_slot_free,
    t4ndef_out_if.source o_out
);

    logic       r_slot_valid;
    t_burst     r_slot;
    logic       r_act;
    t_burst     r_desc;
    logic [3:0] r_pos;
    logic       r_o_valid;
    t_item      r_o;

    logic       adv;
    logic [4:0] blen;
    logic       at_end;
    logic [3:0] k;
    logic [3:0] len;
    logic       take;
    t_item      item;

    assign len    = cmd_len(r_desc.cmd);
    assign blen   = {4'd0, r_desc.has_file} + {1'b0, len} + {4'd0, r_desc.has_status};
    assign at_end = ({1'b0, r_pos} + 5'd1) == blen;
    assign adv    = !r_o_valid || o_out.ready;
    assign take   = r_slot_valid && (!r_act || (adv && at_end));
    assign k      = r_pos - {3'd0, r_desc.has_file};

    always_comb begin
        item = '0;
        if (r_desc.has_file && r_pos == 4'd0) begin
            item.kind     = KIND_FILE;
            item.out_byte = r_desc.file_byte;
        end else if (k < len) begin
            item.kind        = KIND_CMD;
            item.out_byte    = cmd_byte(r_desc.cmd, k, r_desc.arg, r_desc.le);
            item.last_of_run = (k == len - 4'd1);
        end else begin
            item.kind        = KIND_STATUS;
            item.last_of_run = 1'b1;
            item.status_code = r_desc.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= 1'b0;
            r_act        <= 1'b0;
            r_pos        <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (adv) r_o_valid <= r_act;
            if (take) begin
                r_act <= 1'b1;
                r_pos <= '0;
            end else if (adv && r_act) begin
                r_pos <= r_pos + 4'd1;
                if (at_end) r_act <= 1'b0;
            end
            if (i_load)    r_slot_valid <= 1'b1;
            else if (take) r_slot_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_act) r_o <= item;
        if (take)         r_desc <= r_slot;
        if (i_load)       r_slot <= i_burst;
    end

    assign o_slot_free       = !r_slot_valid;
    assign o_out.valid       = r_o_valid;
    assign o_out.kind        = r_o.kind;
    assign o_out.out_byte    = r_o.out_byte;
    assign o_out.last_of_run = r_o.last_of_run;
    assign o_out.status_code = r_o.status_code;

    `T4NDEF_ASSERT_IMPL(a_pos_in_burst, r_act, {1'b0, r_pos} < blen, "position past burst end")
    `T4NDEF_ASSERT_IMPL(a_load_free, i_load, !r_slot_valid, "burst loaded into full slot")
    `T4NDEF_ASSERT_IMPL(a_status_last, r_o_valid && r_o.kind == KIND_STATUS,
        r_o.last_of_run, "status item without end mark")
    `T4NDEF_ASSERT_NEXT(a_take_starts, take, r_act && r_pos == 4'd0, "burst not started")

endmodule
`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the Type 4 tag NDEF read sequencer core.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import t4ndef_pkg::*;

    // Sequencer phases, as tracked by the predictor.
    typedef enum logic [3:0] {
        PH_IDLE, PH_APP2, PH_APP1, PH_SELCC, PH_READCC, PH_SELFILE, PH_NLEN, PH_CHUNK
    } seq_phase_t;

    // Ways to break a read session.
    localparam int F_NONE     = 0;
    localparam int F_APP2     = 1;   // version 2 refused, fall back to version 1
    localparam int F_NOTFOUND = 2;   // both versions refused, 6A82 on the second
    localparam int F_SELCC    = 3;
    localparam int F_CCTYPE   = 4;
    localparam int F_CCLEN    = 5;
    localparam int F_SELFILE  = 6;
    localparam int F_NLEN     = 7;
    localparam int F_SHORT    = 8;   // chunk response one byte short
    localparam int F_LINK     = 9;   // transport failure in the body
    localparam int F_RESTART  = 10;  // new start in the body
    localparam int F_EXTRA    = 11;  // surplus bytes in every chunk
    localparam int F_TINY     = 12;  // one-byte response
    localparam int F_OVERSIZE = 13;  // chunk response longer than the transport allows
    localparam int F_COUNT    = 14;

    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_WAIT   = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 120;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    t4ndef_in_if  in_ch ();
    t4ndef_out_if out_ch ();

    type4_tag_ndef_read_sequencer_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Predictor state: its own copy of the register and the sequencer state.
    logic [15:0] cfg_max_len;
    seq_phase_t  cur_phase;
    logic        detect_mode;
    int          rsp_count;
    logic [15:0] last_two;
    logic [15:0] read_limit;
    logic [15:0] file_id;
    logic        cc_type_ok;
    logic [15:0] msg_len;
    logic [15:0] body_done;
    logic [7:0]  chunk_len;

    t_item due_results[$];
    int    burst_n;
    int    errors;
    int    live_items;
    bit    quiet_tx;
    bit    hold_req;

    // Append one expected output, capped at sixteen per transfer.
    task automatic push_out(input logic [1:0] k, input logic [7:0] b, input logic l,
                            input logic [2:0] c);
        t_item r;
        if (burst_n < 16) begin
            r.kind        = k;
            r.out_byte    = b;
            r.last_of_run = l;
            r.status_code = c;
            due_results.push_back(r);
            burst_n++;
        end
    endtask

    task automatic end_sequence(input logic [2:0] c);
        push_out(KIND_STATUS, 8'h00, 1'b1, c);
        cur_phase = PH_IDLE;
    endtask

    task automatic push_read_cmd(input logic [15:0] offs, input logic [7:0] le);
        push_out(KIND_CMD, 8'h00, 1'b0, ST_OK);
        push_out(KIND_CMD, 8'hB0, 1'b0, ST_OK);
        push_out(KIND_CMD, offs[15:8], 1'b0, ST_OK);
        push_out(KIND_CMD, offs[7:0], 1'b0, ST_OK);
        push_out(KIND_CMD, le, 1'b1, ST_OK);
    endtask

    task automatic push_select_cc();
        for (int k = 0; k < 7; k++) push_out(KIND_CMD, SEL_CC[k], k == 6, ST_OK);
        cur_phase = PH_SELCC;
    endtask

    // Size the next ReadBinary from what is left, the tag's limit and the link's limit.
    task automatic push_next_chunk();
        logic [15:0] c;
        c = msg_len - body_done;
        if (c > 16'(read_limit - 16'd1)) c = read_limit - 16'd1;
        if (c > CHUNK_CAP) c = CHUNK_CAP;
        chunk_len = c[7:0];
        push_read_cmd(16'd2 + body_done, chunk_len);
        cur_phase = PH_CHUNK;
    endtask

    task automatic app_accepted();
        if (detect_mode) end_sequence(ST_OK);
        else push_select_cc();
    endtask

    // Work out every output that one accepted transfer causes.
    task automatic sequencer_step(input logic [1:0] act, input logic [7:0] b, input logic l);
        int  i, n, lim;
        logic [15:0] sw;
        bit  ok;
        burst_n = 0;
        if (act == ACT_DETECT || act == ACT_READ) begin
            detect_mode = (act == ACT_DETECT);
            rsp_count = 0;
            last_two = 16'h0;
            for (int k = 0; k < 13; k++) push_out(KIND_CMD, APP_V2[k], k == 12, ST_OK);
            cur_phase = PH_APP2;
            return;
        end
        if (cur_phase == PH_IDLE) return;
        if (act == ACT_FAIL) begin
            rsp_count = 0;
            last_two = 16'h0;
            end_sequence(ST_TRANSPORT);
            return;
        end
        i = rsp_count;
        // File bytes trail the input by two so the status word never leaks out.
        if (cur_phase == PH_NLEN || cur_phase == PH_CHUNK) begin
            lim = (cur_phase == PH_NLEN) ? 2 : int'(chunk_len);
            if (i >= 2 && i - 2 < lim) push_out(KIND_FILE, last_two[15:8], 1'b0, ST_OK);
        end
        if (cur_phase == PH_READCC) begin
            case (i)
                3:  read_limit[15:8] = b;
                4:  read_limit[7:0]  = b;
                7:  cc_type_ok = (b == CC_TYPE);
                9:  file_id[15:8] = b;
                10: file_id[7:0]  = b;
                default: ;
            endcase
        end else if (cur_phase == PH_NLEN) begin
            if (i == 0) msg_len[15:8] = b;
            else if (i == 1) msg_len[7:0] = b;
        end
        last_two = {last_two[7:0], b};
        if (i < 511) rsp_count = i + 1;
        if (!l) return;

        n = rsp_count;
        sw = last_two;
        rsp_count = 0;
        last_two = 16'h0;
        if (n > TRANSPORT_MAX_RESPONSE) begin
            end_sequence(ST_TRANSPORT);
            return;
        end
        ok = (n >= 2) && (sw == {SW1_OK, 8'h00});
        case (cur_phase)
            PH_APP2: begin
                if (ok) app_accepted();
                else begin
                    for (int k = 0; k < 12; k++) push_out(KIND_CMD, APP_V1[k], k == 11, ST_OK);
                    cur_phase = PH_APP1;
                end
            end
            PH_APP1: begin
                if (ok) app_accepted();
                else if (detect_mode && n >= 2 && sw == {SW1_ERR, SW2_NF})
                    end_sequence(ST_NOTSUPP);
                else end_sequence(ST_IO);
            end
            PH_SELCC: begin
                if (ok) begin
                    push_read_cmd(16'h0000, 8'h0F);
                    cur_phase = PH_READCC;
                end else end_sequence(ST_IO);
            end
            PH_READCC: begin
                if (ok && n == 17 && cc_type_ok) begin
                    if (read_limit < 16'd2) read_limit = 16'd2;
                    for (int k = 0; k < 5; k++) push_out(KIND_CMD, SEL_CC[k], 1'b0, ST_OK);
                    push_out(KIND_CMD, file_id[15:8], 1'b0, ST_OK);
                    push_out(KIND_CMD, file_id[7:0], 1'b1, ST_OK);
                    cur_phase = PH_SELFILE;
                end else end_sequence(ST_IO);
            end
            PH_SELFILE: begin
                if (ok) begin
                    push_read_cmd(16'h0000, 8'd2);
                    cur_phase = PH_NLEN;
                end else end_sequence(ST_IO);
            end
            PH_NLEN: begin
                if (!ok || n != 4) end_sequence(ST_IO);
                else if (msg_len > cfg_max_len) end_sequence(ST_NOSPACE);
                else begin
                    body_done = 16'h0;
                    if (msg_len == 16'h0) end_sequence(ST_OK);
                    else push_next_chunk();
                end
            end
            default: begin
                if (!ok || n - 2 < int'(chunk_len)) end_sequence(ST_IO);
                else begin
                    body_done = body_done + 16'(chunk_len);
                    if (body_done >= msg_len) end_sequence(ST_OK);
                    else push_next_chunk();
                end
            end
        endcase
    endtask

    // Offer one item after a random gap, hold it until the transfer, then predict.
    task automatic send_item(input logic [1:0] act, input logic [7:0] b, input logic l);
        int gap;
        if (quiet_tx) gap = 0;
        else if ($urandom_range(0, 15) == 0) gap = $urandom_range(8, 40);
        else gap = $urandom_range(0, 2);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.action  <= act;
        in_ch.rx_byte <= b;
        in_ch.rx_last <= l;
        do @(posedge i_clk); while (!in_ch.ready);
        if (act != ACT_BYTE && act != ACT_FAIL || cur_phase != PH_IDLE) live_items++;
        sequencer_step(act, b, l);
    endtask

    // Send data bytes then the status word, last marked on its low byte.
    task automatic respond(input logic [7:0] data[$], input logic [15:0] sw);
        foreach (data[k]) send_item(ACT_BYTE, data[k], 1'b0);
        send_item(ACT_BYTE, sw[15:8], 1'b0);
        send_item(ACT_BYTE, sw[7:0], 1'b1);
    endtask

    function automatic logic [15:0] refusal();
        logic [15:0] v;
        v = 16'($urandom);
        if (v == {SW1_OK, 8'h00}) v = {SW1_ERR, SW2_NF};
        return v;
    endfunction

    function automatic logic [15:0] sw_ok();
        return {SW1_OK, 8'h00};
    endfunction

    // Drop valid and wait until every expected output has come, then let the block settle.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= {16'h0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        cfg_max_len = v;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One tag session, well formed except for the chosen fault.
    task automatic run_session(input bit det, input int fault,
                               input logic [15:0] len, input logic [15:0] rlimit);
        logic [7:0] d[$];
        int want;
        send_item(det ? ACT_DETECT : ACT_READ, 8'($urandom), 1'($urandom));
        // Application select, with the version 1 fallback.
        if (fault == F_APP2 || fault == F_NOTFOUND) begin
            d = {};
            respond(d, refusal());
            if (fault == F_NOTFOUND) begin
                respond(d, {SW1_ERR, SW2_NF});
                return;
            end
        end
        d = {};
        respond(d, sw_ok());
        if (cur_phase == PH_IDLE) return;
        if (fault == F_SELCC) begin
            respond(d, refusal());
            return;
        end
        if (fault == F_TINY) begin
            send_item(ACT_BYTE, 8'($urandom), 1'b1);
            return;
        end
        respond(d, sw_ok());
        // Capability container: read limit at 3..4, type at 7, file id at 9..10.
        for (int k = 0; k < 15; k++) d.push_back(8'($urandom));
        d[3] = rlimit[15:8];
        d[4] = rlimit[7:0];
        d[7] = (fault == F_CCTYPE) ? (8'($urandom) | 8'h08) : CC_TYPE;
        if (fault == F_CCLEN) void'(d.pop_back());
        respond(d, sw_ok());
        if (cur_phase == PH_IDLE) return;
        d = {};
        respond(d, (fault == F_SELFILE) ? refusal() : sw_ok());
        if (cur_phase == PH_IDLE) return;
        d = {len[15:8], len[7:0]};
        if (fault == F_NLEN) d.push_back(8'($urandom));
        respond(d, sw_ok());
        while (cur_phase == PH_CHUNK) begin
            if (fault == F_LINK && $urandom_range(0, 1) == 0) begin
                send_item(ACT_FAIL, 8'($urandom), 1'($urandom));
                return;
            end
            if (fault == F_RESTART && $urandom_range(0, 1) == 0) begin
                run_session($urandom_range(0, 1), F_NONE, len, rlimit);
                return;
            end
            want = chunk_len;
            if (fault == F_SHORT) want = want - 1;
            if (fault == F_EXTRA) want = want + $urandom_range(1, 3);
            if (fault == F_OVERSIZE) want = TRANSPORT_MAX_RESPONSE - 1 + $urandom_range(0, 3);
            d = {};
            for (int k = 0; k < want; k++) d.push_back(8'($urandom));
            respond(d, sw_ok());
        end
    endtask

    task automatic test_detect();
        run_session(1'b1, F_NONE, 16'd0, 16'd2);
        run_session(1'b1, F_APP2, 16'd0, 16'd2);
        run_session(1'b1, F_NOTFOUND, 16'd0, 16'd2);
        run_session(1'b0, F_NOTFOUND, 16'd0, 16'd2);
        // Stray input while idle is ignored.
        send_item(ACT_BYTE, 8'hFF, 1'b1);
        send_item(ACT_FAIL, 8'h00, 1'b0);
        wait_idle();
    endtask

    task automatic test_read_basic();
        run_session(1'b0, F_NONE, 16'd5, 16'd3);
        run_session(1'b0, F_NONE, 16'd0, 16'd40);
        run_session(1'b0, F_NONE, 16'd4, 16'h0000);
        wait_idle();
    endtask

    // The oversized case reads a long file so the chunk also hits the link's limit.
    task automatic test_faults();
        for (int f = F_APP2; f < F_COUNT; f++)
            run_session(1'b0, f, (f == F_OVERSIZE) ? 16'd300 : 16'd1,
                        (f == F_OVERSIZE) ? 16'hFFFF : 16'd4);
        wait_idle();
    endtask

    task automatic test_config_limits();
        cfg_write(16'h0000);
        run_session(1'b0, F_NONE, 16'd1, 16'd8);
        run_session(1'b0, F_NONE, 16'd0, 16'd8);
        wait_idle();
        cfg_write(16'hFFFF);
        run_session(1'b0, F_NONE, 16'd3, 16'd8);
        wait_idle();
        cfg_write(16'd1024);
        run_session(1'b0, F_NONE, 16'd1025, 16'd8);
        wait_idle();
    endtask

    // Stall the receiver for a long stretch while the sender keeps pushing.
    task automatic test_backpressure();
        quiet_tx = 1'b1;
        hold_req = 1'b1;
        run_session(1'b0, F_NONE, 16'd12, 16'd5);
        run_session(1'b0, F_LINK, 16'd12, 16'd5);
        quiet_tx = 1'b0;
        wait_idle();
    endtask

    task automatic test_random();
        int fault;
        int live_start;
        logic [15:0] len, rl;
        live_start = live_items;
        while (live_items < live_start + RANDOM_ITEMS) begin
            quiet_tx = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0) begin
                // Noise: any item at all.
                send_item(2'($urandom), 8'($urandom), 1'($urandom));
                continue;
            end
            fault = ($urandom_range(0, 9) < 6) ? F_NONE : $urandom_range(F_APP2, F_COUNT - 2);
            len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 80))
                                              : 16'($urandom_range(0, 30));
            case ($urandom_range(0, 9))
                0:       rl = 16'hFFFF;
                1:       rl = 16'($urandom);
                default: rl = 16'($urandom_range(0, 12));
            endcase
            run_session($urandom_range(0, 5) == 0, fault, len, rl);
            if ($urandom_range(0, 7) == 0) begin
                wait_idle();
                if ($urandom_range(0, 2) == 0) cfg_write(16'($urandom_range(0, 40)));
                else cfg_write(16'($urandom));
            end
        end
        wait_idle();
    endtask

    // Result side: random ready with occasional long stalls, plus one held-off stretch.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if ($urandom_range(0, 150) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(8, 40)) @(posedge i_clk);
            end else begin
                out_ch.ready <= quiet_tx || ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Compare each output transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_item e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected output kind=%0d byte=%h last=%0d status=%0d", $time,
                         out_ch.kind, out_ch.out_byte, out_ch.last_of_run, out_ch.status_code);
                errors++;
            end else begin
                e = due_results.pop_front();
                if (out_ch.kind !== e.kind || out_ch.out_byte !== e.out_byte ||
                    out_ch.last_of_run !== e.last_of_run ||
                    out_ch.status_code !== e.status_code) begin
                    $display("%0t: mismatch expected kind=%0d byte=%h last=%0d status=%0d",
                             $time, e.kind, e.out_byte, e.last_of_run, e.status_code);
                    $display("%0t:          actual   kind=%0d byte=%h last=%0d status=%0d",
                             $time, out_ch.kind, out_ch.out_byte, out_ch.last_of_run,
                             out_ch.status_code);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("type4_tag_ndef_read_sequencer_core regression: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.action  = ACT_BYTE;
        in_ch.rx_byte = 8'h00;
        in_ch.rx_last = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'd0;
        pwdata        = 32'h0;
        errors        = 0;
        live_items    = 0;
        quiet_tx      = 1'b0;
        hold_req      = 1'b0;
        // Predictor reset state.
        cfg_max_len = 16'd1024;
        cur_phase   = PH_IDLE;
        detect_mode = 1'b0;
        rsp_count   = 0;
        last_two    = 16'h0;
        read_limit  = 16'd2;
        file_id     = 16'h0;
        cc_type_ok  = 1'b0;
        msg_len     = 16'h0;
        body_done   = 16'h0;
        chunk_len   = 8'h0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_detect();
        test_read_basic();
        test_faults();
        test_config_limits();
        test_backpressure();
        test_random();

        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("type4_tag_ndef_read_sequencer_core regression: pass");
        end else begin
            $display("type4_tag_ndef_read_sequencer_core regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
